// File: design/mpsl_pkg.sv
// Shared types and constants of the multi-channel PID speed loop.
package mpsl_pkg;

  localparam int GainCount  = 6;
  localparam int FracBits   = 25;
  localparam int CfgIdxW    = 3;

  localparam logic [CfgIdxW-1:0] RegLegP   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLegI   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLegD   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSlideP = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSlideI = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSlideD = 3'd5;

  typedef struct packed {
    logic [2:0]         channel;
    logic signed [15:0] target_speed;
    logic signed [15:0] measured_speed;
    logic [15:0]        elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_channel;
    logic signed [15:0] drive;
    logic               saturated;
  } out_item_t;

  // Start request for the serial multiplier.
  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [47:0] b;
    logic [5:0]  n;
  } mul_req_t;

endpackage

// File: design/mpsl_mul.sv
// Bit-serial unsigned multiplier: one bit of the multiplier per cycle.
module mpsl_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpsl_pkg::mul_req_t req_i,
  output logic              done_o,
  output logic [79:0]       prod_o
);

  logic [32:0] hi_q, hi_d;
  logic [47:0] lo_q, lo_d;
  logic [31:0] a_q, a_d;
  logic [5:0]  n_q, n_d, cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] sum;
  logic [80:0] full;

  always_comb begin
    sum    = lo_q[0] ? (hi_q + {1'b0, a_q}) : hi_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    a_d    = a_q;
    n_d    = n_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      hi_d   = '0;
      lo_d   = req_i.b;
      a_d    = req_i.a;
      n_d    = req_i.n;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      hi_d  = {1'b0, sum[32:1]};
      lo_d  = {sum[0], lo_q[47:1]};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == n_q - 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    a_q  <= a_d;
    n_q  <= n_d;
  end

  // After n steps the product sits at the top of the shift pair.
  assign full   = {hi_q, lo_q};
  assign prod_o = 80'(full >> (6'd48 - n_q));
  assign done_o = done_q;

endmodule

// File: design/mpsl_div.sv
// Restoring divider: one quotient bit per cycle, 51-bit dividend by 16-bit divisor.
module mpsl_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [50:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [50:0] quo_o
);

  logic [15:0] rem_q, rem_d, den_q, den_d;
  logic [50:0] num_q, num_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        fits;

  always_comb begin
    trial  = {rem_q, num_q[50]};
    diff   = trial - {1'b0, den_q};
    fits   = trial >= {1'b0, den_q};
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      num_d  = num_i;
      den_d  = den_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[15:0] : trial[15:0];
      num_d = {num_q[49:0], fits};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd50) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

// File: design/multi_channel_pid_speed_loop.sv
// Top level of the multi-channel PID speed loop with trapezoidal integral.
// An item for a valid channel runs the serial multiplier for four products (18, 17, 18
// and 48 steps), with the divider's 51 steps between the third and the fourth, and the
// result then loads into the output register. A channel out of range skips the
// arithmetic and goes straight to the output stage. One item is in work at a time: the
// next one is taken only after the result has loaded, which a stalled output holds back.
// Reset clears gains, stored errors and integrals, and all control.
module multi_channel_pid_speed_loop #(
  parameter int NUM_CHANNELS = 5
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  mpsl_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output mpsl_pkg::out_item_t              out_item_o,
  input  logic                             cfg_we_i,
  input  logic [mpsl_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [31:0]                      cfg_data_i
);

  localparam int ChW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INC  = 3'd1;
  localparam logic [2:0] S_P    = 3'd2;
  localparam logic [2:0] S_D    = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_I    = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [31:0] gain_q [mpsl_pkg::GainCount];
  logic [16:0] last_err_q [NUM_CHANNELS];
  logic [47:0] integ_q [NUM_CHANNELS];

  logic [2:0]  ch_q, ch_d;
  logic [15:0] dt_q, dt_d;
  logic [16:0] e_q, e_d, prev_q, prev_d;
  logic [47:0] acc_q, acc_d;
  logic [62:0] sum_q, sum_d;
  logic        neg_q, neg_d, sat_q, sat_d;
  logic        out_valid_q, out_valid_d;
  mpsl_pkg::out_item_t out_item_q, out_item_d;

  mpsl_pkg::mul_req_t mul_req;
  logic        mul_done, div_start, div_done;
  logic [79:0] mul_prod;
  logic [50:0] div_num, div_quo;

  logic [ChW-1:0] in_idx, idx;
  logic        in_ok;
  logic [16:0] in_e, in_prev;
  logic [17:0] in_s, in_s_mag;
  logic        slide;
  logic [31:0] gp, gi, gd, gp_mag, gi_mag, gd_mag;
  logic [16:0] e_mag;
  logic [17:0] diff, diff_mag;
  logic [47:0] integ, acc_mag;
  logic [48:0] inc49, acc49;
  logic [60:0] im;
  logic [62:0] term;
  logic [37:0] drv38;
  logic        drv_sat, wr_state, load_out;

  mpsl_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  mpsl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (dt_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    in_idx   = ChW'(in_item_i.channel);
    in_ok    = 32'(in_item_i.channel) < NUM_CHANNELS;
    in_e     = {in_item_i.target_speed[15], in_item_i.target_speed}
             - {in_item_i.measured_speed[15], in_item_i.measured_speed};
    in_prev  = in_ok ? last_err_q[in_idx] : '0;
    in_s     = {in_prev[16], in_prev} + {in_e[16], in_e};
    in_s_mag = in_s[17] ? -in_s : in_s;

    idx      = ChW'(ch_q);
    slide    = 32'(ch_q) == NUM_CHANNELS - 1;
    gp       = slide ? gain_q[mpsl_pkg::RegSlideP] : gain_q[mpsl_pkg::RegLegP];
    gi       = slide ? gain_q[mpsl_pkg::RegSlideI] : gain_q[mpsl_pkg::RegLegI];
    gd       = slide ? gain_q[mpsl_pkg::RegSlideD] : gain_q[mpsl_pkg::RegLegD];
    gp_mag   = gp[31] ? -gp : gp;
    gi_mag   = gi[31] ? -gi : gi;
    gd_mag   = gd[31] ? -gd : gd;
    e_mag    = e_q[16] ? -e_q : e_q;
    diff     = {e_q[16], e_q} - {prev_q[16], prev_q};
    diff_mag = diff[17] ? -diff : diff;
    integ    = integ_q[idx];
    acc_mag  = acc_q[47] ? -acc_q : acc_q;

    // Sum of the two errors times dt (twice the trapezoid area), added to the stored integral with 48-bit clipping.
    inc49 = {15'd0, mul_prod[33:0]};
    acc49 = {integ[47], integ} + (neg_q ? -inc49 : inc49);
    im    = (mul_prod >= (80'd1 << 60)) ? (61'd1 << 60) : mul_prod[60:0];

    drv38   = 38'($signed(sum_q) >>> mpsl_pkg::FracBits);
    drv_sat = !((&drv38[37:15]) || !(|drv38[37:15]));

    state_d   = state_q;
    ch_d      = ch_q;
    dt_d      = dt_q;
    e_d       = e_q;
    prev_d    = prev_q;
    acc_d     = acc_q;
    sum_d     = sum_q;
    neg_d     = neg_q;
    sat_d     = sat_q;
    mul_req   = '0;
    div_start = 1'b0;
    div_num   = {1'b0, mul_prod[48:0], 1'b0};
    wr_state  = 1'b0;
    load_out  = 1'b0;
    term      = '0;
    out_item_d = out_item_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ch_d   = in_item_i.channel;
          dt_d   = (in_item_i.elapsed_us == 16'd0) ? 16'd1 : in_item_i.elapsed_us;
          e_d    = in_e;
          prev_d = in_prev;
          neg_d  = in_s[17];
          sum_d  = '0;
          sat_d  = 1'b0;
          if (in_ok) begin
            mul_req.start = 1'b1;
            mul_req.a     = {16'd0, dt_d};
            mul_req.b     = 48'(in_s_mag);
            mul_req.n     = 6'd18;
            state_d       = S_INC;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_INC: begin
        if (mul_done) begin
          wr_state = 1'b1;
          if (acc49[48] != acc49[47]) begin
            acc_d = acc49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
            sat_d = 1'b1;
          end else begin
            acc_d = acc49[47:0];
          end
          neg_d         = gp[31] ^ e_q[16];
          mul_req.start = 1'b1;
          mul_req.a     = gp_mag;
          mul_req.b     = 48'(e_mag);
          mul_req.n     = 6'd17;
          state_d       = S_P;
        end
      end
      S_P: begin
        if (mul_done) begin
          term          = 63'({mul_prod[48:0], 1'b0});
          sum_d         = sum_q + (neg_q ? -term : term);
          neg_d         = gd[31] ^ diff[17];
          mul_req.start = 1'b1;
          mul_req.a     = gd_mag;
          mul_req.b     = 48'(diff_mag);
          mul_req.n     = 6'd18;
          state_d       = S_D;
        end
      end
      S_D: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          term          = 63'(div_quo);
          sum_d         = sum_q + (neg_q ? -term : term);
          neg_d         = gi[31] ^ acc_q[47];
          mul_req.start = 1'b1;
          mul_req.a     = gi_mag;
          mul_req.b     = acc_mag;
          mul_req.n     = 6'd48;
          state_d       = S_I;
        end
      end
      S_I: begin
        if (mul_done) begin
          term    = 63'(im);
          sum_d   = sum_q + (neg_q ? -term : term);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out               = 1'b1;
          out_item_d.out_channel = ch_q;
          out_item_d.saturated   = sat_q || drv_sat;
          if (drv_sat) begin
            out_item_d.drive = drv38[37] ? 16'sh8000 : 16'sh7FFF;
          end else begin
            out_item_d.drive = drv38[15:0];
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int k = 0; k < mpsl_pkg::GainCount; k++) begin
        gain_q[k] <= '0;
      end
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        last_err_q[k] <= '0;
        integ_q[k]    <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (32'(cfg_index_i) < mpsl_pkg::GainCount)) begin
        gain_q[cfg_index_i] <= cfg_data_i;
      end
      if (wr_state) begin
        last_err_q[idx] <= e_q;
        integ_q[idx]    <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    dt_q       <= dt_d;
    e_q        <= e_d;
    prev_q     <= prev_d;
    acc_q      <= acc_d;
    sum_q      <= sum_d;
    neg_q      <= neg_d;
    sat_q      <= sat_d;
    out_item_q <= out_item_d;
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: test/multi_channel_pid_speed_loop_tb.sv
// Self-checking testbench of the multi-channel PID speed loop with a predicting scoreboard.
module multi_channel_pid_speed_loop_tb;

  localparam int NumCh = 5;
  localparam int RegCount = 8;  // index field reaches past the six gains

  class speed_loop_model;
    longint gain[mpsl_pkg::GainCount];
    longint prev_err[NumCh];
    longint err_sum[NumCh];
    mpsl_pkg::out_item_t expected_drives[$];
    int mismatches;
    int checked;

    function new();
      foreach (gain[k]) gain[k] = 0;
      foreach (prev_err[k]) begin
        prev_err[k] = 0;
        err_sum[k] = 0;
      end
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_gain(logic [mpsl_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
      if (idx < mpsl_pkg::GainCount) gain[idx] = longint'($signed(val));
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction

    // Works out the drive for one accepted item and queues it.
    function void note_item(mpsl_pkg::in_item_t it);
      mpsl_pkg::out_item_t res;
      longint e, prev, acc, dt, gp, gi, gd, p_t, i_t, d_t, sum, drv;
      logic [95:0] a_mag, b_mag, prod;
      logic [95:0] lim;
      int base;
      bit sat;
      res.out_channel = it.channel;
      res.drive = '0;
      res.saturated = 1'b0;
      if (it.channel < NumCh) begin
        sat = 0;
        lim = 96'd1 << 60;
        dt = (it.elapsed_us == 0) ? 1 : longint'(it.elapsed_us);
        base = (it.channel == NumCh - 1) ? int'(mpsl_pkg::RegSlideP)
                                         : int'(mpsl_pkg::RegLegP);
        gp = gain[base];
        gi = gain[base + 1];
        gd = gain[base + 2];
        e = longint'($signed(it.target_speed)) - longint'($signed(it.measured_speed));
        prev = prev_err[it.channel];
        acc = err_sum[it.channel] + (prev + e) * dt;
        if (acc > 64'sh7FFF_FFFF_FFFF) begin
          acc = 64'sh7FFF_FFFF_FFFF;
          sat = 1;
        end
        if (acc < -64'sh8000_0000_0000) begin
          acc = -64'sh8000_0000_0000;
          sat = 1;
        end
        err_sum[it.channel] = acc;
        prev_err[it.channel] = e;
        p_t = 2 * gp * e;
        d_t = (2 * gd * (e - prev)) / dt;
        a_mag = (gi < 0) ? 96'(-gi) : 96'(gi);
        b_mag = (acc < 0) ? 96'(-acc) : 96'(acc);
        prod = a_mag * b_mag;
        if (prod > lim) prod = lim;
        i_t = ((gi < 0) != (acc < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
        sum = p_t + i_t + d_t;
        drv = sum >>> mpsl_pkg::FracBits;
        if (drv > 32767) begin
          drv = 32767;
          sat = 1;
        end
        if (drv < -32768) begin
          drv = -32768;
          sat = 1;
        end
        res.drive = drv[15:0];
        res.saturated = sat;
      end
      expected_drives.push_back(res);
    endfunction

    task report(string what);
      mismatches++;
      $display("mismatch: %s", what);
    endtask

    task check_drive(mpsl_pkg::out_item_t got);
      mpsl_pkg::out_item_t want;
      if (expected_drives.size() == 0) begin
        report($sformatf("unexpected result ch %0d drive %0d", got.out_channel, got.drive));
        return;
      end
      want = expected_drives.pop_front();
      checked++;
      if (got.out_channel !== want.out_channel)
        report($sformatf("channel got %0d want %0d", got.out_channel, want.out_channel));
      if (got.drive !== want.drive)
        report($sformatf("ch %0d drive got %0d want %0d", want.out_channel, got.drive,
                         want.drive));
      if (got.saturated !== want.saturated)
        report($sformatf("ch %0d saturated got %0b want %0b", want.out_channel,
                         got.saturated, want.saturated));
    endtask
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, cfg_we_i;
  mpsl_pkg::in_item_t in_item_i;
  mpsl_pkg::out_item_t out_item_o;
  logic [mpsl_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  speed_loop_model sb = new();
  bit calm;       // no idling on either side while set
  bit hold_req;   // asks the receiver for one long hold-off
  int sent;

  multi_channel_pid_speed_loop #(.NUM_CHANNELS(NumCh)) uut (.*);

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(20 * 1_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: checks every accepted item and stalls at random or for a long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_drive(out_item_o);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 32);
      end
    end
  end

  task automatic write_reg(logic [mpsl_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_gain(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(mpsl_pkg::in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    sent++;
    if (!calm && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic mpsl_pkg::in_item_t make_item(logic [2:0] ch, int tgt, int meas,
                                                   int dt);
    mpsl_pkg::in_item_t it;
    it.channel = ch;
    it.target_speed = tgt[15:0];
    it.measured_speed = meas[15:0];
    it.elapsed_us = dt[15:0];
    return it;
  endfunction

  function automatic mpsl_pkg::in_item_t rand_item();
    mpsl_pkg::in_item_t it;
    int spd;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(mpsl_pkg::in_item_t)-1:0];
    if ($urandom_range(99) < 90) it.channel = 3'($urandom_range(NumCh - 1));
    if ($urandom_range(99) < 50) begin
      // Speeds near each other, as in a loop that tracks well.
      spd = $urandom_range(0, 8000) - 4000;
      it.target_speed = spd[15:0];
      spd = spd + $urandom_range(0, 400) - 200;
      it.measured_speed = spd[15:0];
    end
    case ($urandom_range(9))
      0: it.elapsed_us = '0;
      1, 2: ;
      default: it.elapsed_us = 16'($urandom_range(1, 2000));
    endcase
    return it;
  endfunction

  function automatic logic [31:0] small_gain(int bits);
    return 32'($urandom_range(0, 2 ** (bits + 1)) - 2 ** bits);
  endfunction

  task automatic load_gains(int mode);
    for (int r = 0; r < RegCount; r++) begin
      case (mode)
        0: write_reg(r[mpsl_pkg::CfgIdxW-1:0], (r % 3 == 1) ? small_gain(8) : small_gain(22));
        1: write_reg(r[mpsl_pkg::CfgIdxW-1:0], 32'h7FFF_FFFF);
        2: write_reg(r[mpsl_pkg::CfgIdxW-1:0], 32'h8000_0000);
        3: write_reg(r[mpsl_pkg::CfgIdxW-1:0], r[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
        default: write_reg(r[mpsl_pkg::CfgIdxW-1:0], $urandom);
      endcase
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    calm = 0;
    hold_req = 0;
    sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Gains are still zero after reset.
    send_item(make_item(3'd0, 1000, -1000, 100));
    send_item(make_item(3'd4, 32767, -32768, 65535));
    drain();

    write_reg(mpsl_pkg::RegLegP, 32'h0100_0000);
    write_reg(mpsl_pkg::RegLegI, 32'h0000_0100);
    write_reg(mpsl_pkg::RegLegD, 32'h0080_0000);
    write_reg(mpsl_pkg::RegSlideP, 32'hFF00_0000);
    write_reg(mpsl_pkg::RegSlideI, 32'hFFFF_FF00);
    write_reg(mpsl_pkg::RegSlideD, 32'hFF80_0000);
    write_reg(3'd6, 32'h7FFF_FFFF);  // beyond the gain list, ignored
    write_reg(3'd7, 32'h8000_0000);
    send_item(make_item(3'd0, 32767, -32768, 65535));
    send_item(make_item(3'd0, -32768, 32767, 65535));
    send_item(make_item(3'd1, 100, 50, 0));           // zero elapsed time
    send_item(make_item(3'd1, 100, 50, 1));
    send_item(make_item(3'd2, 0, 0, 65535));
    send_item(make_item(3'd3, -32768, -32768, 1));
    send_item(make_item(3'd4, 32767, -32768, 0));
    send_item(make_item(3'd4, -32768, 32767, 1));
    send_item(make_item(3'd4, 10, 20, 1000));
    send_item(make_item(3'd5, 500, 0, 10));           // channels out of range
    send_item(make_item(3'd6, -500, 0, 10));
    send_item(make_item(3'd7, 32767, -32768, 0));
    send_item(make_item(3'd2, 20, -20, 3));
    send_item(make_item(3'd3, 32767, 32767, 65535));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      load_gains((ph == 5) ? 0 : ph);
      calm = (ph == 3);
      for (int n = 0; n < 180; n++) begin
        if (ph == 1 && n == 20) hold_req = 1;
        send_item(rand_item());
      end
      drain();
    end
    calm = 0;

    // Push one wheel integral hard with the largest steps, then reverse.
    load_gains(0);
    calm = 1;
    for (int n = 0; n < 50; n++) send_item(make_item(3'd0, 32767, -32768, 65535));
    send_item(make_item(3'd0, -32768, 32767, 65535));
    calm = 0;
    drain();

    $display("Sent %0d items under several gain settings, %0d results checked.", sent,
             sb.checked);
    $display("Covered gain extremes, out-of-range channels, zero time and a long hold-off.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
